// File: design/lbc_pkg.sv
// shared types, constants and functions for the lilliput block cipher
// s-box, nibble permutations, op codes, sequencer states; no dependencies
package lbc_pkg;

  // input operation codes
  typedef enum logic [1:0] {
    OP_KEY = 2'd0,
    OP_ENC = 2'd1,
    OP_DEC = 2'd2
  } op_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_t;

  // control for the shared round unit
  typedef struct packed {
    logic dec;
    logic last;
  } round_ctrl_t;

  localparam logic [5:0] ROUNDS_RST = 6'd30;

  localparam logic [3:0] SBOX [16] = '{
    4'h4, 4'h8, 4'h7, 4'h1, 4'h9, 4'h3, 4'h2, 4'hE,
    4'h0, 4'hB, 4'h6, 4'hF, 4'hA, 4'h5, 4'hD, 4'hC
  };

  localparam logic [3:0] PERM_FWD [16] = '{
    4'd13, 4'd9, 4'd14, 4'd8, 4'd10, 4'd11, 4'd12, 4'd15,
    4'd4, 4'd5, 4'd3, 4'd1, 4'd2, 4'd6, 4'd0, 4'd7
  };

  localparam logic [3:0] PERM_BWD [16] = '{
    4'd14, 4'd11, 4'd12, 4'd10, 4'd8, 4'd9, 4'd13, 4'd15,
    4'd3, 4'd1, 4'd4, 4'd5, 4'd6, 4'd0, 4'd2, 4'd7
  };

  // 4-bit s-box lookup
  function automatic logic [3:0] sbox(input logic [3:0] x);
    return SBOX[x];
  endfunction

  // nibble i moves to position p[i]
  function automatic logic [63:0] permute(input logic [63:0] blk, input logic dec);
    logic [63:0] t;
    logic [3:0]  p;
    t = '0;
    for (int i = 0; i < 16; i++) begin
      p = dec ? PERM_BWD[i] : PERM_FWD[i];
      t[4*p +: 4] = blk[4*i +: 4];
    end
    return t;
  endfunction

endpackage

// File: design/lbc_key_mem.sv
// round key store: one write port, one registered read port
// stand-alone; no package dependency
module lbc_key_mem #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [31:0]   wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [31:0]   rd_data
);

  logic [31:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: design/lbc_round.sv
// shared round unit: keyed s-box layer, xor layer, optional nibble permutation
// depends on lbc_pkg for the s-box, permutations and control struct
module lbc_round (
  input  logic [63:0]              blk_in,
  input  logic [31:0]              rkey,
  input  lbc_pkg::round_ctrl_t     ctrl,
  output logic [63:0]              blk_out
);

  logic [63:0] nx;

  // nonlinear and linear layers, both from the values before the round
  always_comb begin
    nx = blk_in;
    for (int i = 0; i < 8; i++) begin
      nx[4*(i+8) +: 4] = nx[4*(i+8) +: 4]
                         ^ lbc_pkg::sbox(blk_in[4*(7-i) +: 4] ^ rkey[4*i +: 4]);
    end
    for (int i = 1; i < 8; i++) begin
      nx[63:60] = nx[63:60] ^ blk_in[4*i +: 4];
    end
    for (int i = 9; i < 15; i++) begin
      nx[4*i +: 4] = nx[4*i +: 4] ^ blk_in[31:28];
    end
  end

  // permutation skipped after the last round
  assign blk_out = ctrl.last ? nx : lbc_pkg::permute(nx, ctrl.dec);

endmodule

// File: design/lilliput_block_cipher.sv
// lilliput 64-bit block cipher top level: sequencer, key store, round unit
// depends on lbc_pkg, lbc_key_mem and lbc_round
// key write: one beat a cycle while idle. encrypt/decrypt: the input beat loads the
// working block, then R rounds run one a cycle through the round unit, each with its
// key read from the registered key store in the cycle before; the result register
// loads once free, and only then is the next beat taken. R = the configured round count
// capped at MAX_ROUNDS. synchronous reset sets R to 30; the key store is not cleared
module lilliput_block_cipher #(
  parameter int MAX_ROUNDS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [5:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_op,
  input  logic [63:0] in_block_in,
  input  logic [4:0]  in_key_index,
  input  logic [31:0] in_key_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_block_out
);

  localparam int AW = (MAX_ROUNDS > 1) ? $clog2(MAX_ROUNDS) : 1;
  localparam int CW = $clog2(MAX_ROUNDS + 1);

  lbc_pkg::state_t st_r, st_nxt;

  logic [5:0]    rounds_cfg_r;
  logic [63:0]   block_r;
  logic          dec_r;
  logic [CW-1:0] rem_r;
  logic [AW-1:0] ka_r;
  logic          out_valid_r;
  logic [63:0]   out_block_r;

  logic [6:0]    nr_ext, nr_cap, kidx_ext;
  logic [CW-1:0] nr_sat, nr_m1;
  logic          in_acc, start, is_dec, last, out_free, load_out;
  logic          wr_en, rd_en;
  logic [AW-1:0] rd_addr;
  logic [31:0]   rkey;
  logic [63:0]   rnd_out;
  lbc_pkg::round_ctrl_t rctrl;

  // round count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rounds_cfg_r <= lbc_pkg::ROUNDS_RST;
    end else if (cfg_we) begin
      rounds_cfg_r <= cfg_wdata;
    end
  end

  // round count capped at the table depth
  assign nr_ext = {1'b0, rounds_cfg_r};
  assign nr_cap = (nr_ext > 7'(MAX_ROUNDS)) ? 7'(MAX_ROUNDS) : nr_ext;
  assign nr_sat = nr_cap[CW-1:0];
  assign nr_m1  = nr_sat - CW'(1);

  // input beat decode
  assign in_acc   = in_valid && in_ready;
  assign is_dec   = (in_op == lbc_pkg::OP_DEC);
  assign start    = in_acc && ((in_op == lbc_pkg::OP_ENC) || is_dec);
  assign kidx_ext = {2'b00, in_key_index};
  assign wr_en    = in_acc && (in_op == lbc_pkg::OP_KEY) && (kidx_ext < 7'(MAX_ROUNDS));
  assign last     = (rem_r == CW'(1));
  assign out_free = !out_valid_r || out_ready;

  // key read address, one round ahead
  always_comb begin
    priority if (start) begin
      rd_addr = is_dec ? nr_m1[AW-1:0] : '0;
    end else if (last) begin
      rd_addr = ka_r;
    end else if (dec_r) begin
      rd_addr = ka_r - AW'(1);
    end else begin
      rd_addr = ka_r + AW'(1);
    end
  end

  lbc_key_mem #(
    .DEPTH (MAX_ROUNDS),
    .AW    (AW)
  ) u_key_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (kidx_ext[AW-1:0]),
    .wr_data (in_key_value),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rkey)
  );

  assign rctrl.dec  = dec_r;
  assign rctrl.last = last;

  lbc_round u_round (
    .blk_in  (block_r),
    .rkey    (rkey),
    .ctrl    (rctrl),
    .blk_out (rnd_out)
  );

  // sequencer next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      lbc_pkg::ST_IDLE: begin
        if (start) begin
          st_nxt = (nr_sat == '0) ? lbc_pkg::ST_DONE : lbc_pkg::ST_RUN;
        end
      end
      lbc_pkg::ST_RUN: begin
        if (last) begin
          st_nxt = lbc_pkg::ST_DONE;
        end
      end
      lbc_pkg::ST_DONE: begin
        if (out_free) begin
          st_nxt = lbc_pkg::ST_IDLE;
        end
      end
      default: st_nxt = lbc_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready = (st_r == lbc_pkg::ST_IDLE);
    rd_en    = start || (st_r == lbc_pkg::ST_RUN);
    load_out = (st_r == lbc_pkg::ST_DONE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= lbc_pkg::ST_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  // round counter and key address
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
      ka_r  <= '0;
      dec_r <= 1'b0;
    end else if (start) begin
      rem_r <= nr_sat;
      ka_r  <= rd_addr;
      dec_r <= is_dec;
    end else if (st_r == lbc_pkg::ST_RUN) begin
      rem_r <= rem_r - CW'(1);
      ka_r  <= rd_addr;
    end
  end

  // working block
  always_ff @(posedge clk) begin
    if (start) begin
      block_r <= in_block_in;
    end else if (st_r == lbc_pkg::ST_RUN) begin
      block_r <= rnd_out;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_block_r <= block_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_block_out = out_block_r;

endmodule

// File: dv/lilliput_block_cipher_test.sv
// self-checking testbench for lilliput_block_cipher: key loads, encrypt and decrypt
// beats against a local cipher predictor; depends on lbc_pkg and the rtl top level
`timescale 1ns / 1ps

module lilliput_block_cipher_test;

  localparam int         MAX_ROUNDS  = 32;
  localparam int         CYCLE_LIMIT = 1_000_000;
  localparam int         REPORT_MAX  = 10;
  localparam logic [1:0] OP_NONE     = 2'd3;

  // cipher tables kept apart from the design's copies
  localparam logic [3:0] SUB_TAB [16] = '{
    4'h4, 4'h8, 4'h7, 4'h1, 4'h9, 4'h3, 4'h2, 4'hE,
    4'h0, 4'hB, 4'h6, 4'hF, 4'hA, 4'h5, 4'hD, 4'hC
  };
  localparam int FWD_DEST [16] = '{13, 9, 14, 8, 10, 11, 12, 15, 4, 5, 3, 1, 2, 6, 0, 7};
  localparam int BWD_DEST [16] = '{14, 11, 12, 10, 8, 9, 13, 15, 3, 1, 4, 5, 6, 0, 2, 7};

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_RANDOM,
    RX_SPARSE,
    RX_BLOCKED
  } rx_mode_t;

  typedef struct {
    logic [1:0]  op;
    logic [63:0] src;
    logic [63:0] result;
  } cipher_expect_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [5:0]  cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_op = lbc_pkg::OP_KEY;
  logic [63:0] in_block_in = '0;
  logic [4:0]  in_key_index = '0;
  logic [31:0] in_key_value = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] out_block_out;

  // predictor state
  logic [31:0]    key_table [MAX_ROUNDS];
  logic [5:0]     rounds_cfg = lbc_pkg::ROUNDS_RST;
  cipher_expect_t cipher_expect_q [$];

  int       fail_count = 0;
  int       beats_sent = 0;
  int       blocks_checked = 0;
  int       rounds_writes = 0;
  int       burst_left = 0;
  int       cycle_count = 0;
  int       rx_tick = 0;
  rx_mode_t rx_mode = RX_OPEN;

  lilliput_block_cipher #(
    .MAX_ROUNDS(MAX_ROUNDS)
  ) u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_op        (in_op),
    .in_block_in  (in_block_in),
    .in_key_index (in_key_index),
    .in_key_value (in_key_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_block_out(out_block_out)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d blocks outstanding", cycle_count,
               cipher_expect_q.size());
      $display("FAIL");
      $finish;
    end
  end

  // one round: keyed s-boxes into the upper branches plus the xor layer
  function automatic logic [63:0] feistel_round(input logic [63:0] s, input logic [31:0] k);
    logic [63:0] n;
    n = s;
    for (int i = 0; i < 8; i++)
      n[4*(i+8) +: 4] ^= SUB_TAB[s[4*(7-i) +: 4] ^ k[4*i +: 4]];
    for (int i = 1; i < 8; i++)
      n[63:60] ^= s[4*i +: 4];
    for (int i = 9; i < 15; i++)
      n[4*i +: 4] ^= s[31:28];
    return n;
  endfunction

  // branch i lands at the table's position for i
  function automatic logic [63:0] nibble_shuffle(input logic [63:0] s, input logic back);
    logic [63:0] t;
    int          dest;
    t = '0;
    for (int i = 0; i < 16; i++) begin
      dest = back ? BWD_DEST[i] : FWD_DEST[i];
      t[4*dest +: 4] = s[4*i +: 4];
    end
    return t;
  endfunction

  // full encrypt or decrypt at the current round count
  function automatic logic [63:0] cipher_predict(input logic [1:0] op, input logic [63:0] blk);
    logic [63:0] s;
    int          nr;
    s  = blk;
    nr = (rounds_cfg > MAX_ROUNDS) ? MAX_ROUNDS : int'(rounds_cfg);
    if (op == lbc_pkg::OP_ENC) begin
      for (int r = 0; r < nr; r++) begin
        s = feistel_round(s, key_table[r]);
        if (r + 1 < nr) s = nibble_shuffle(s, 1'b0);
      end
    end else begin
      for (int r = nr; r > 0; r--) begin
        s = feistel_round(s, key_table[r-1]);
        if (r - 1 != 0) s = nibble_shuffle(s, 1'b1);
      end
    end
    return s;
  endfunction

  function automatic void log_failure(input string msg);
    fail_count++;
    if (fail_count <= REPORT_MAX) $display("%s", msg);
  endfunction

  // result check and receiver stall pattern
  always @(posedge clk) begin
    cipher_expect_t e;
    if (rst_n && out_valid && out_ready) begin
      if (cipher_expect_q.size() == 0) begin
        log_failure($sformatf("unexpected result beat %h", out_block_out));
      end else begin
        e = cipher_expect_q.pop_front();
        blocks_checked++;
        if (out_block_out !== e.result)
          log_failure($sformatf("%s of %h: expected %h, got %h",
                                (e.op == lbc_pkg::OP_ENC) ? "encrypt" : "decrypt",
                                e.src, e.result, out_block_out));
      end
    end
    rx_tick++;
    if (rx_tick % 97 == 0) rx_mode = rx_mode_t'($urandom_range(0, 3));
    case (rx_mode)
      RX_OPEN:    out_ready <= 1'b1;
      RX_RANDOM:  out_ready <= 1'($urandom_range(0, 1));
      RX_SPARSE:  out_ready <= (rx_tick % 5 == 0);
      default:    out_ready <= (rx_tick % 16) >= 10;
    endcase
  end

  // send one beat in bursts with random gaps, then record what it should give
  task automatic send_item(input logic [1:0] op, input logic [63:0] blk,
                           input logic [4:0] kidx, input logic [31:0] kval);
    cipher_expect_t e;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk);
      burst_left = $urandom_range(1, 64);
    end
    in_valid     <= 1'b1;
    in_op        <= op;
    in_block_in  <= blk;
    in_key_index <= kidx;
    in_key_value <= kval;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    beats_sent++;
    // a key write beyond the table would be dropped; a 5-bit index never gets there
    if (op == lbc_pkg::OP_KEY) begin
      if (kidx < MAX_ROUNDS) key_table[kidx] = kval;
    end else if (op == lbc_pkg::OP_ENC || op == lbc_pkg::OP_DEC) begin
      e.op     = op;
      e.src    = blk;
      e.result = cipher_predict(op, blk);
      cipher_expect_q.push_back(e);
    end
  endtask

  // stop sending, wait for every block, then let a trailing key write or dropped op finish
  task automatic settle();
    in_valid <= 1'b0;
    while (cipher_expect_q.size() != 0) @(posedge clk);
    repeat (MAX_ROUNDS + 4) @(posedge clk);
  endtask

  task automatic set_rounds(input logic [5:0] v);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we     <= 1'b0;
    rounds_cfg = v;
    rounds_writes++;
  endtask

  // every table entry is written before any block reads it
  task automatic test_key_load();
    for (int i = 0; i < MAX_ROUNDS; i++)
      send_item(lbc_pkg::OP_KEY, '0, 5'(i), $urandom);
  endtask

  // field extremes, round trip, unused op and key rewrites at the reset round count
  task automatic test_directed();
    logic [63:0] p;
    p = {$urandom, $urandom};
    send_item(lbc_pkg::OP_ENC, '0, '0, '0);
    send_item(lbc_pkg::OP_ENC, '1, '1, '1);
    send_item(lbc_pkg::OP_DEC, '0, '0, '0);
    send_item(lbc_pkg::OP_DEC, '1, '0, '0);
    send_item(lbc_pkg::OP_ENC, p, '0, '0);
    send_item(lbc_pkg::OP_DEC, cipher_predict(lbc_pkg::OP_ENC, p), '0, '0);
    send_item(OP_NONE, '1, '1, '1);
    send_item(OP_NONE, '0, '0, '0);
    send_item(lbc_pkg::OP_KEY, '1, 5'd31, '1);
    send_item(lbc_pkg::OP_KEY, '0, 5'd0, '0);
    send_item(lbc_pkg::OP_ENC, {$urandom, $urandom}, '0, '0);
    send_item(lbc_pkg::OP_DEC, {$urandom, $urandom}, '0, '0);
  endtask

  // zero rounds passes through, above the table size saturates
  task automatic test_round_limits();
    logic [5:0] limits [5];
    limits = '{6'd0, 6'd1, 6'd32, 6'd33, 6'd63};
    foreach (limits[i]) begin
      set_rounds(limits[i]);
      send_item(lbc_pkg::OP_ENC, {$urandom, $urandom}, '0, '0);
      send_item(lbc_pkg::OP_DEC, {$urandom, $urandom}, '0, '0);
    end
  endtask

  // mostly blocks, some key rewrites and unused ops, over several round counts
  task automatic test_random();
    logic [5:0] phase_rounds [10];
    logic [1:0] op;
    int         pick;
    phase_rounds = '{lbc_pkg::ROUNDS_RST, 6'd1, 6'd5, 6'd32, 6'd63, 6'd0, 6'd16,
                     6'($urandom_range(2, 31)), 6'($urandom_range(2, 31)), 6'd31};
    foreach (phase_rounds[ph]) begin
      set_rounds(phase_rounds[ph]);
      for (int n = 0; n < 200; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 45)      op = lbc_pkg::OP_ENC;
        else if (pick < 85) op = lbc_pkg::OP_DEC;
        else if (pick < 95) op = lbc_pkg::OP_KEY;
        else                op = OP_NONE;
        send_item(op, {$urandom, $urandom}, 5'($urandom), $urandom);
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_key_load();
    test_directed();
    test_round_limits();
    test_random();
    settle();
    $display("covered %0d input beats and %0d checked blocks over %0d round-count writes",
             beats_sent, blocks_checked, rounds_writes);
    $display("round counts included zero, one, the table size and saturated values");
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("%0d failures", fail_count);
      $display("FAIL");
    end
    $finish;
  end

endmodule
